// ----- src/rbi_pkg.sv -----
// ----------------------------------------------------------------------------
// rbi_pkg: shared types and constants of the ray/box intersection unit
// Item layouts, coordinate and parameter widths, face normal codes.
// ----------------------------------------------------------------------------
package rbi_pkg;

   localparam int COORD_BITS  = 16;
   localparam int T_FRAC_BITS = 16;
   // quotient bits of the divider pipelines: enough for entry_t and a contact
   // offset, whose magnitude can reach 2^(COORD_BITS-1)
   localparam int QUO_BITS    = (COORD_BITS > T_FRAC_BITS) ? COORD_BITS + 1
                                                           : T_FRAC_BITS + 1;

   typedef enum logic [1:0] {
      NORM_NEG_X = 2'd0,
      NORM_POS_X = 2'd1,
      NORM_POS_Y = 2'd2,
      NORM_NEG_Y = 2'd3
   } normal_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] origin_x;
      logic signed [COORD_BITS-1:0] origin_y;
      logic signed [COORD_BITS-1:0] dir_x;
      logic signed [COORD_BITS-1:0] dir_y;
      logic signed [COORD_BITS-1:0] box_min_x;
      logic signed [COORD_BITS-1:0] box_min_y;
      logic signed [COORD_BITS-1:0] box_max_x;
      logic signed [COORD_BITS-1:0] box_max_y;
   } req_type;

   typedef struct packed {
      logic                         hit;
      logic [T_FRAC_BITS:0]         entry_t;
      logic signed [COORD_BITS-1:0] contact_x;
      logic signed [COORD_BITS-1:0] contact_y;
      normal_type                   normal_code;
   } rsp_type;

   // one slab: near/far numerators over the common positive denominator
   typedef struct packed {
      logic signed [COORD_BITS+1:0] near;
      logic signed [COORD_BITS+1:0] far;
      logic [COORD_BITS-1:0]        den;
      logic                         free;
      logic                         ok;
   } axis_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] ox;
      logic signed [COORD_BITS-1:0] oy;
      logic signed [COORD_BITS-1:0] dx;
      logic signed [COORD_BITS-1:0] dy;
   } ctx_type;

endpackage

// ----- src/rbi_div.sv -----
// ----------------------------------------------------------------------------
// rbi_div: pipelined restoring divider
// One quotient bit per stage, MSB first; carries a sideband with each item.
// ----------------------------------------------------------------------------
module rbi_div #(
   parameter int DW = 17,
   parameter int QB = 17,
   parameter int SW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [DW+QB-1:0] num,
   input  logic [DW-1:0]    den,
   input  logic [SW-1:0]    side,
   output logic             out_valid,
   output logic [QB-1:0]    quo,
   output logic [SW-1:0]    out_side
);
   localparam int RW = DW + QB;

   logic [QB-1:0] vld_ff;
   logic [RW-1:0] rem_ff  [QB];
   logic [DW-1:0] den_ff  [QB];
   logic [QB-1:0] quo_ff  [QB];
   logic [SW-1:0] side_ff [QB];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[QB-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic [RW-1:0] rem_p;
      logic [DW-1:0] den_p;
      logic [QB-1:0] quo_p;
      logic [SW-1:0] side_p;
      logic [RW:0]   sub;
      logic [RW-1:0] rem_in;
      logic [QB-1:0] quo_in;

      if (k == 0) begin : g_first
         assign rem_p  = num;
         assign den_p  = den;
         assign quo_p  = '0;
         assign side_p = side;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign den_p  = den_ff[k-1];
         assign quo_p  = quo_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      always_comb begin
         sub = {1'b0, rem_p} - ((RW+1)'(den_p) << (QB - 1 - k));
         if (sub[RW]) begin
            rem_in = rem_p;
            quo_in = quo_p;
         end else begin
            rem_in = sub[RW-1:0];
            quo_in = quo_p | (QB'(1) << (QB - 1 - k));
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_p;
            quo_ff[k]  <= quo_in;
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = vld_ff[QB-1];
   assign quo       = quo_ff[QB-1];
   assign out_side  = side_ff[QB-1];

endmodule

// ----- src/ray_box_intersect_2d_unit.sv -----
// ----------------------------------------------------------------------------
// ray_box_intersect_2d_unit: 2D segment against axis-aligned box, slab test
// Gives hit flag, entry parameter, contact point and face normal per item.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one item per cycle (req_valid / req_stall), a segment
//     origin + t*dir, t in [0,1], and a box, all signed Q8.8.
//   rsp channel: one result item per request item, in order (rsp_valid /
//     rsp_stall). Misses come back with every field zero.
//   Pipeline: 5 front stages (slabs, cross products, compare, scale,
//     numerator setup), QUO_BITS divider stages (17 at default widths, one
//     quotient bit per stage) and the output register.
//   Throughput: one item per cycle while not stalled; the bit-per-stage divider
//     pipelines set the depth but not the rate.
//   Stall: while a waiting result is stalled the whole pipeline holds and
//     req_stall is raised; items already inside are neither lost nor repeated.
//     An unstalled output lets a new item in the same cycle.
//   Reset: synchronous, clears all valid bits; no warm-up needed.
// ----------------------------------------------------------------------------
module ray_box_intersect_2d_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rbi_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rbi_pkg::rsp_type rsp_data
);
   import rbi_pkg::*;

   localparam int C    = COORD_BITS;
   localparam int T    = T_FRAC_BITS;
   localparam int PW   = 2*C + 3;
   localparam int DW   = C + 1;
   localparam int RW   = DW + QUO_BITS;
   localparam int SW_T = 3;
   localparam int SW_C = 3*C + 3;

   // advance the whole pipeline unless a finished result is held back
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   function automatic axis_type slab_calc(input logic signed [C-1:0] o, d, lo, hi);
      logic signed [C:0]   a;
      logic signed [C:0]   b;
      logic signed [C+1:0] an;
      logic signed [C+1:0] bn;
      axis_type            r;
      a      = (C+1)'(lo) - (C+1)'(o);
      b      = (C+1)'(hi) - (C+1)'(o);
      // flip to a positive denominator
      an     = d[C-1] ? -(C+2)'(a) : (C+2)'(a);
      bn     = d[C-1] ? -(C+2)'(b) : (C+2)'(b);
      r.near = (an < bn) ? an : bn;
      r.far  = (an < bn) ? bn : an;
      r.den  = d[C-1] ? C'(-d) : C'(d);
      r.free = (d == '0);
      // zero direction: origin must lie strictly between the bounds
      r.ok   = !r.free || (a < 0 && b > 0) || (a > 0 && b < 0);
      return r;
   endfunction

   // ---- stage 1: slabs per axis
   logic     s1_valid_ff;
   axis_type s1_x_ff, s1_y_ff;
   ctx_type  s1_ctx_ff;
   logic     s1_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff <= slab_calc(req_data.origin_x, req_data.dir_x,
                              req_data.box_min_x, req_data.box_max_x);
         s1_y_ff <= slab_calc(req_data.origin_y, req_data.dir_y,
                              req_data.box_min_y, req_data.box_max_y);
         s1_ctx_ff  <= '{ox: req_data.origin_x, oy: req_data.origin_y,
                         dx: req_data.dir_x,    dy: req_data.dir_y};
         s1_zero_ff <= (req_data.dir_x == '0) && (req_data.dir_y == '0);
      end
   end

   // ---- stage 2: cross products for the rational compares
   logic signed [PW-1:0] p_nxdy_in, p_fydx_in, p_nydx_in, p_fxdy_in;
   logic signed [PW-1:0] p_nxdy_ff, p_fydx_ff, p_nydx_ff, p_fxdy_ff;
   logic     s2_valid_ff;
   axis_type s2_x_ff, s2_y_ff;
   ctx_type  s2_ctx_ff;
   logic     s2_zero_ff;

   always_comb begin
      p_nxdy_in = PW'(s1_x_ff.near) * PW'($signed({1'b0, s1_y_ff.den}));
      p_fydx_in = PW'(s1_y_ff.far)  * PW'($signed({1'b0, s1_x_ff.den}));
      p_nydx_in = PW'(s1_y_ff.near) * PW'($signed({1'b0, s1_x_ff.den}));
      p_fxdy_in = PW'(s1_x_ff.far)  * PW'($signed({1'b0, s1_y_ff.den}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_nxdy_ff  <= p_nxdy_in;
         p_fydx_ff  <= p_fydx_in;
         p_nydx_ff  <= p_nydx_in;
         p_fxdy_ff  <= p_fxdy_in;
         s2_x_ff    <= s1_x_ff;
         s2_y_ff    <= s1_y_ff;
         s2_ctx_ff  <= s1_ctx_ff;
         s2_zero_ff <= s1_zero_ff;
      end
   end

   // ---- stage 3: overlap, entry face, range of t
   logic                hit3_in, xface3_in, sep3;
   logic signed [C+1:0] tn3;
   logic [C-1:0]        td3;
   normal_type          nc3_in;
   logic                s3_valid_ff, s3_hit_ff, s3_xface_ff;
   logic [C-1:0]        s3_tnum_ff, s3_tden_ff;
   normal_type          s3_nc_ff;
   ctx_type             s3_ctx_ff;

   always_comb begin
      sep3      = (p_nxdy_ff > p_fydx_ff) || (p_nydx_ff > p_fxdy_ff);
      // y face wins ties
      xface3_in = !s2_x_ff.free && (s2_y_ff.free || (p_nxdy_ff > p_nydx_ff));
      tn3       = xface3_in ? s2_x_ff.near : s2_y_ff.near;
      td3       = xface3_in ? s2_x_ff.den  : s2_y_ff.den;
      hit3_in   = !s2_zero_ff && s2_x_ff.ok && s2_y_ff.ok
                  && !(!s2_x_ff.free && !s2_y_ff.free && sep3)
                  && !(tn3 < 0) && !(tn3 > $signed({2'b00, td3}));
      if (xface3_in) begin
         nc3_in = (s2_ctx_ff.dx > 0) ? NORM_NEG_X : NORM_POS_X;
      end else begin
         nc3_in = (s2_ctx_ff.dy < 0) ? NORM_POS_Y : NORM_NEG_Y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_hit_ff   <= hit3_in;
         s3_xface_ff <= xface3_in;
         s3_tnum_ff  <= tn3[C-1:0];
         s3_tden_ff  <= td3;
         s3_nc_ff    <= nc3_in;
         s3_ctx_ff   <= s2_ctx_ff;
      end
   end

   // ---- stage 4: scale the other axis by t's numerator
   logic signed [C-1:0] od4, fd4;
   logic [C-1:0]        omag4;
   logic [2*C-1:0]      prod4_in;
   logic signed [C:0]   foff4_in;
   logic                s4_valid_ff, s4_hit_ff, s4_xface_ff, s4_neg_ff;
   logic [2*C-1:0]      s4_prod_ff;
   logic [C-1:0]        s4_tnum_ff, s4_tden_ff;
   logic signed [C:0]   s4_foff_ff;
   normal_type          s4_nc_ff;
   logic signed [C-1:0] s4_ox_ff, s4_oy_ff;

   always_comb begin
      od4      = s3_xface_ff ? s3_ctx_ff.dy : s3_ctx_ff.dx;
      fd4      = s3_xface_ff ? s3_ctx_ff.dx : s3_ctx_ff.dy;
      omag4    = od4[C-1] ? C'(-od4) : C'(od4);
      prod4_in = (2*C)'(omag4) * (2*C)'(s3_tnum_ff);
      // along the face axis the contact offset is exact: sign(d) * num
      foff4_in = fd4[C-1] ? -$signed({1'b0, s3_tnum_ff}) : $signed({1'b0, s3_tnum_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_hit_ff   <= s3_hit_ff;
         s4_xface_ff <= s3_xface_ff;
         s4_neg_ff   <= od4[C-1];
         s4_prod_ff  <= prod4_in;
         s4_tnum_ff  <= s3_tnum_ff;
         s4_tden_ff  <= s3_tden_ff;
         s4_foff_ff  <= foff4_in;
         s4_nc_ff    <= s3_nc_ff;
         s4_ox_ff    <= s3_ctx_ff.ox;
         s4_oy_ff    <= s3_ctx_ff.oy;
      end
   end

   // ---- stage 5: rounding numerators, floor((2p + q - neg) / 2q)
   logic [RW-1:0]   nt5_in, nc5_in;
   logic [DW-1:0]   d5_in;
   logic            s5_valid_ff;
   logic [RW-1:0]   s5_nt_ff, s5_nc_ff;
   logic [DW-1:0]   s5_d_ff;
   logic [SW_T-1:0] s5_side_t_ff;
   logic [SW_C-1:0] s5_side_c_ff;

   always_comb begin
      nt5_in = RW'(((C+T+1)'(s4_tnum_ff) << (T + 1)) + (C+T+1)'(s4_tden_ff));
      nc5_in = RW'(((2*C)'(s4_prod_ff) << 1) + (2*C)'(s4_tden_ff)
                   - (2*C)'(s4_neg_ff));
      d5_in  = DW'(s4_tden_ff) << 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_nt_ff     <= nt5_in;
         s5_nc_ff     <= nc5_in;
         s5_d_ff      <= d5_in;
         s5_side_t_ff <= {s4_hit_ff, s4_nc_ff};
         s5_side_c_ff <= {s4_xface_ff, s4_neg_ff, s4_foff_ff, s4_ox_ff, s4_oy_ff};
      end
   end

   // ---- divider pipelines
   logic                t_valid, c_valid;
   logic [QUO_BITS-1:0] q_t, q_c;
   logic [SW_T-1:0]     side_t;
   logic [SW_C-1:0]     side_c;

   rbi_div #(.DW(DW), .QB(QUO_BITS), .SW(SW_T)) u_div_t (
      .clock    (clock),
      .reset    (reset),
      .advance  (adv),
      .in_valid (s5_valid_ff),
      .num      (s5_nt_ff),
      .den      (s5_d_ff),
      .side     (s5_side_t_ff),
      .out_valid(t_valid),
      .quo      (q_t),
      .out_side (side_t)
   );

   rbi_div #(.DW(DW), .QB(QUO_BITS), .SW(SW_C)) u_div_c (
      .clock    (clock),
      .reset    (reset),
      .advance  (adv),
      .in_valid (s5_valid_ff),
      .num      (s5_nc_ff),
      .den      (s5_d_ff),
      .side     (s5_side_c_ff),
      .out_valid(c_valid),
      .quo      (q_c),
      .out_side (side_c)
   );

   // ---- output: contact point, saturate, zero on miss
   logic                f_hit, f_xface, f_neg;
   normal_type          f_nc;
   logic signed [C:0]   f_foff, f_other;
   logic signed [C-1:0] f_ox, f_oy;
   logic signed [C+1:0] sum_x, sum_y;
   logic signed [C-1:0] sat_x, sat_y;
   rsp_type             rsp_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   function automatic logic signed [C-1:0] sat_coord(input logic signed [C+1:0] v);
      logic signed [C-1:0] r;
      if ((v[C+1:C-1] == 3'b000) || (v[C+1:C-1] == 3'b111)) begin
         r = v[C-1:0];
      end else if (v[C+1]) begin
         r = {1'b1, {(C-1){1'b0}}};
      end else begin
         r = {1'b0, {(C-1){1'b1}}};
      end
      return r;
   endfunction

   always_comb begin
      {f_hit, f_nc}                           = side_t;
      {f_xface, f_neg, f_foff, f_ox, f_oy}    = side_c;
      // offset magnitude reaches 2^(C-1), so keep the quotient's top bit
      f_other = f_neg ? -$signed(q_c[C:0]) : $signed(q_c[C:0]);
      sum_x   = (C+2)'(f_ox) + (C+2)'(f_xface ? f_foff : f_other);
      sum_y   = (C+2)'(f_oy) + (C+2)'(f_xface ? f_other : f_foff);
      sat_x   = sat_coord(sum_x);
      sat_y   = sat_coord(sum_y);
      if (f_hit) begin
         rsp_in.hit         = 1'b1;
         rsp_in.entry_t     = q_t[T:0];
         rsp_in.contact_x   = sat_x;
         rsp_in.contact_y   = sat_y;
         rsp_in.normal_code = f_nc;
      end else begin
         rsp_in.hit         = 1'b0;
         rsp_in.entry_t     = '0;
         rsp_in.contact_x   = '0;
         rsp_in.contact_y   = '0;
         rsp_in.normal_code = NORM_NEG_X;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= t_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- checks
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      t_valid == c_valid)
      else $error("divider pipelines out of step");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.entry_t == '0
         && rsp_data.contact_x == '0 && rsp_data.contact_y == '0
         && rsp_data.normal_code == NORM_NEG_X)
      else $error("miss item carries nonzero fields");

   a_t_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> rsp_data.entry_t <= ((T+1)'(1) << T))
      else $error("entry parameter above one");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(t_valid) && $stable(q_t))
      else $error("pipeline moved under a stalled result");

endmodule

// ----- test/tb_ray_box_intersect_2d_unit.sv -----
// ----------------------------------------------------------------------------
// tb_ray_box_intersect_2d_unit: self-checking bench of the ray/box unit
// Streams segment/box items through the unit, predicts each result with an
// exact rational slab test and compares every returned item field by field.
// ----------------------------------------------------------------------------
module tb_ray_box_intersect_2d_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import rbi_pkg::*;

   localparam int LATENCY = 23;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   ray_box_intersect_2d_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   req_type pending_items[$];
   rsp_type expected_hits[$];
   int      errors = 0;
   int      items_sent = 0;
   int      results_seen = 0;
   int      hits_seen = 0;
   bit      calm_phase = 0;     // no idling in the last part of the run
   bit      hold_rsp = 0;       // long receiver hold-off request
   bit      hold_req = 0;       // sender pause until drained
   bit      req_taken = 0;      // item accepted at the last rising edge

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // floor(p/q + 1/2), q > 0
   function automatic longint round_div(longint p, longint q);
      longint d, r;
      d = p / q;
      r = p % q;
      if (r < 0) begin
         d -= 1;
         r += q;
      end
      if (2 * r >= q) d += 1;
      return d;
   endfunction

   function automatic longint clamp_coord(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // slab of one axis; returns 0 on a miss
   function automatic bit axis_slab(longint o, longint d, longint lo, longint hi,
                                    output bit free_axis, output longint near_n,
                                    output longint far_n, output longint den);
      longint a, b;
      a = lo - o;
      b = hi - o;
      free_axis = 0;
      near_n = 0;
      far_n = 0;
      den = 1;
      if (d == 0) begin
         free_axis = 1;
         return (a < 0 && b > 0) || (a > 0 && b < 0);
      end
      if (d < 0) begin
         a = -a;
         b = -b;
         d = -d;
      end
      den = d;
      near_n = (a < b) ? a : b;
      far_n = (a < b) ? b : a;
      return 1;
   endfunction

   function automatic rsp_type predict_intersection(req_type it);
      rsp_type r;
      longint ox, oy, dx, dy;
      longint nxn, fxn, dxd, nyn, fyn, dyd, tn, td;
      bit freex, freey, xface;
      r = '0;
      ox = it.origin_x; oy = it.origin_y;
      dx = it.dir_x;    dy = it.dir_y;
      if (dx == 0 && dy == 0) return r;
      if (!axis_slab(ox, dx, it.box_min_x, it.box_max_x, freex, nxn, fxn, dxd))
         return r;
      if (!axis_slab(oy, dy, it.box_min_y, it.box_max_y, freey, nyn, fyn, dyd))
         return r;
      if (!freex && !freey) begin
         if (nxn * dyd > fyn * dxd || nyn * dxd > fxn * dyd) return r;
      end
      xface = !freex && (freey || nxn * dyd > nyn * dxd);
      tn = xface ? nxn : nyn;
      td = xface ? dxd : dyd;
      if (tn < 0 || tn > td) return r;
      r.hit = 1'b1;
      r.entry_t = 17'(round_div(tn * 65536, td));
      r.contact_x = 16'(clamp_coord(ox + round_div(dx * tn, td)));
      r.contact_y = 16'(clamp_coord(oy + round_div(dy * tn, td)));
      if (xface) r.normal_code = (dx > 0) ? NORM_NEG_X : NORM_POS_X;
      else       r.normal_code = (dy < 0) ? NORM_POS_Y : NORM_NEG_Y;
      return r;
   endfunction

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         1:       return 16'($signed($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   // well-formed case: box around a target, segment aimed at or near it
   function automatic req_type aimed_item();
      req_type it;
      int cx, cy, hw, hh, ox, oy;
      int span;
      span = $urandom_range(0, 3) == 0 ? 30000 : 3000;
      cx = $urandom_range(0, 2 * span) - span;
      cy = $urandom_range(0, 2 * span) - span;
      hw = $urandom_range(0, 1500);
      hh = $urandom_range(0, 1500);
      ox = cx + $urandom_range(0, 8000) - 4000;
      oy = cy + $urandom_range(0, 8000) - 4000;
      it.origin_x = 16'(ox);
      it.origin_y = 16'(oy);
      it.dir_x = 16'((cx - ox) * $urandom_range(1, 3) / 2 + $urandom_range(0, 200) - 100);
      it.dir_y = 16'((cy - oy) * $urandom_range(1, 3) / 2 + $urandom_range(0, 200) - 100);
      if ($urandom_range(0, 9) == 0) it.dir_x = 0;
      if ($urandom_range(0, 9) == 0) it.dir_y = 0;
      it.box_min_x = 16'(cx - hw);
      it.box_max_x = 16'(cx + hw);
      it.box_min_y = 16'(cy - hh);
      it.box_max_y = 16'(cy + hh);
      if ($urandom_range(0, 15) == 0) begin
         it.box_min_x = 16'(cx + hw);
         it.box_max_x = 16'(cx - hw);
      end
      return it;
   endfunction

   function automatic req_type noise_item();
      req_type it;
      it.origin_x = rand_coord();  it.origin_y = rand_coord();
      it.dir_x = rand_coord();     it.dir_y = rand_coord();
      it.box_min_x = rand_coord(); it.box_min_y = rand_coord();
      it.box_max_x = rand_coord(); it.box_max_y = rand_coord();
      return it;
   endfunction

   function automatic req_type make_item(int ox, int oy, int dx, int dy,
                                         int lx, int ly, int hx, int hy);
      req_type it;
      it.origin_x = 16'(ox);  it.origin_y = 16'(oy);
      it.dir_x = 16'(dx);     it.dir_y = 16'(dy);
      it.box_min_x = 16'(lx); it.box_min_y = 16'(ly);
      it.box_max_x = 16'(hx); it.box_max_y = 16'(hy);
      return it;
   endfunction

   // Driver: advance on acceptance, insert random gaps, honor the pause.
   int req_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // move on only once the held item was taken at the last rising edge
         if (!req_valid || req_taken) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (!hold_req && pending_items.size() > 0) begin
               req_data <= pending_items.pop_front();
               req_valid <= 1'b1;
               if (!calm_phase && $urandom_range(0, 9) == 0)
                  req_gap <= $urandom_range(1, 5);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Expectations are recorded at the accepting edge.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_hits.push_back(predict_intersection(req_data));
         items_sent++;
      end
   end

   // Receiver stall: random bursts, plus a long hold-off on request.
   int rsp_burst = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else if (rsp_burst > 0) begin
         rsp_burst <= rsp_burst - 1;
         rsp_stall <= 1'b1;
      end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
         rsp_burst <= $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_hits.size() == 0) begin
            $display("%0t: unexpected result item %h", $time, rsp_data);
            errors++;
         end else begin
            exp_r = expected_hits.pop_front();
            if (rsp_data.hit) hits_seen++;
            if (rsp_data.hit !== exp_r.hit ||
                rsp_data.entry_t !== exp_r.entry_t ||
                rsp_data.contact_x !== exp_r.contact_x ||
                rsp_data.contact_y !== exp_r.contact_y ||
                rsp_data.normal_code !== exp_r.normal_code) begin
               $display("%0t: mismatch expected hit=%b t=%0d cx=%0d cy=%0d n=%0d",
                        $time, exp_r.hit, exp_r.entry_t, exp_r.contact_x,
                        exp_r.contact_y, exp_r.normal_code);
               $display("%0t:          actual   hit=%b t=%0d cx=%0d cy=%0d n=%0d",
                        $time, rsp_data.hit, rsp_data.entry_t, rsp_data.contact_x,
                        rsp_data.contact_y, rsp_data.normal_code);
               errors++;
            end
         end
      end
   end

   // Hard limit on run time.
   initial begin
      #5ms;
      $display("timeout with %0d results outstanding", expected_hits.size());
      $display("simulation failed");
      $finish;
   end

   initial begin
      int n;
      req_valid = 1'b0;
      rsp_stall = 1'b0;
      req_data = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes, zero direction, free axes, bounds, faces, clamping.
      pending_items.push_back(make_item(0, 0, 0, 0, -256, -256, 256, 256));
      pending_items.push_back(make_item(-512, 0, 1024, 0, -256, -256, 256, 256));
      pending_items.push_back(make_item(512, 0, -1024, 0, -256, -256, 256, 256));
      pending_items.push_back(make_item(0, 512, 0, -1024, -256, -256, 256, 256));
      pending_items.push_back(make_item(0, -512, 0, 1024, -256, -256, 256, 256));
      pending_items.push_back(make_item(-256, 0, 0, 1024, -256, -512, 256, 512));
      pending_items.push_back(make_item(-512, 0, 0, 1024, -256, -256, 256, 256));
      pending_items.push_back(make_item(0, 0, 100, 100, -256, -256, 256, 256));
      pending_items.push_back(make_item(-512, -512, 1024, 1024, -256, -256, 256, 256));
      pending_items.push_back(make_item(-512, 0, 1024, 0, 256, 256, -256, -256));
      pending_items.push_back(make_item(-512, 0, 256, 0, -256, -256, 256, 256));
      pending_items.push_back(make_item(-512, 0, 1, 0, -256, -256, 256, 256));
      pending_items.push_back(make_item(32767, 32767, -32768, -32768,
                                        -32768, -32768, 32767, 32767));
      pending_items.push_back(make_item(-32768, -32768, 32767, 32767,
                                        -100, -100, 100, 100));
      pending_items.push_back(make_item(32767, 0, -32768, 1, -32768, -1, -32767, 1));
      pending_items.push_back(make_item(-32768, 32767, 32767, -32768,
                                        32767, -32768, 32767, -32768));
      pending_items.push_back(make_item(0, 0, 32767, 32767, 32760, 32760, 32767, 32767));
      pending_items.push_back(make_item(0, 0, -32768, -32768, -32768, -32768, -32760, -32760));
      pending_items.push_back(make_item(256, 300, -512, 0, -256, -256, 256, 256));
      pending_items.push_back(make_item(-300, 0, 600, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                                        16'haaaa, 16'h5555, 16'haaaa, 16'h5555));

      // Random: mostly aimed segments, the rest noise.
      for (int i = 0; i < 400; i++)
         pending_items.push_back($urandom_range(0, 3) == 0 ? noise_item() : aimed_item());

      // Long receiver hold-off while the sender keeps offering items.
      wait (items_sent > 100);
      hold_rsp = 1;
      n = 0;
      while (n < 80) begin
         @(posedge clock);
         n++;
      end
      hold_rsp = 0;

      // Sender pause until everything has drained.
      wait (pending_items.size() == 0);
      hold_req = 1;
      for (int i = 0; i < 430; i++)
         pending_items.push_back($urandom_range(0, 3) == 0 ? noise_item() : aimed_item());
      wait (expected_hits.size() == 0 && !req_valid);
      hold_req = 0;

      wait (pending_items.size() == 0);
      calm_phase = 1;
      for (int i = 0; i < 400; i++)
         pending_items.push_back($urandom_range(0, 3) == 0 ? noise_item() : aimed_item());

      wait (pending_items.size() == 0 && !req_valid);
      wait (expected_hits.size() == 0);
      repeat (LATENCY + 5) @(posedge clock);

      $display("%0d items driven, %0d results checked (%0d hits), incl. stall and drain phases",
               items_sent, results_seen, hits_seen);
      if (errors == 0 && expected_hits.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
